// ----- src/sli_pkg.sv -----
// ----------------------------------------------------------------------------
// sli_pkg
// Shared constants and types of the sorted list insertion block.
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int SLI_CAPACITY = 16;
	localparam int SLI_KEY_W    = 32;
	localparam int SLI_CNT_W    = $clog2(SLI_CAPACITY + 1);

	typedef logic signed [SLI_KEY_W-1:0] sli_key_t;
	typedef logic [SLI_CNT_W-1:0]        sli_cnt_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DUMP   = 1'b1
	} sli_op_t;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_FULL = 1'b1
	} sli_status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE
	} sli_cell_op_t;

	typedef struct packed {
		sli_cell_op_t op;
		sli_key_t     key;
	} sli_cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} sli_state_t;

endpackage

// ----- src/sli_if.sv -----
// ----------------------------------------------------------------------------
// sli_if
// Valid/ready channels for the item input and the result output.
// ----------------------------------------------------------------------------
interface sli_item_if;
	logic              valid;
	logic              ready;
	logic              operation;
	sli_pkg::sli_key_t key;

	modport source (output valid, output operation, output key, input ready);
	modport sink   (input valid, input operation, input key, output ready);
endinterface

interface sli_result_if;
	logic              valid;
	logic              ready;
	sli_pkg::sli_key_t value;
	logic              value_present;
	logic              last;
	logic              status;

	modport source (output valid, output value, output value_present, output last,
		output status, input ready);
	modport sink   (input valid, input value, input value_present, input last,
		input status, output ready);
endinterface

// ----- src/sli_cell.sv -----
// ----------------------------------------------------------------------------
// sli_cell
// One place of the sorted row: compares the broadcast key, shifts up on an
// insert and takes its upper neighbour's key on a rotate.
// ----------------------------------------------------------------------------
module sli_cell (
	input  logic                  clk,
	input  sli_pkg::sli_cell_cmd_t cmd,
	input  logic                  occ,
	input  logic                  prev_occ,
	input  logic                  prev_ge,
	input  sli_pkg::sli_key_t     prev_val,
	input  logic                  next_occ,
	input  sli_pkg::sli_key_t     next_val,
	input  sli_pkg::sli_key_t     head_val,
	output logic                  ge,
	output sli_pkg::sli_key_t     val
);
	import sli_pkg::*;

	sli_key_t val_q;
	sli_key_t val_d;
	logic     load;

	assign ge  = occ && !(val_q < cmd.key);
	assign val = val_q;

	always_comb begin
		load  = 1'b0;
		val_d = val_q;
		case (cmd.op)
			CELL_INSERT: begin
				load  = ge || (!occ && prev_occ);
				val_d = prev_ge ? prev_val : cmd.key;
			end
			CELL_ROTATE: begin
				load  = occ;
				val_d = next_occ ? next_val : head_val;
			end
			default: begin
				load  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= val_d;
		end
	end

endmodule

// ----- src/sli_chain.sv -----
// ----------------------------------------------------------------------------
// sli_chain
// Row of cells holding the keys in ascending order, lowest at the head.
// ----------------------------------------------------------------------------
module sli_chain (
	input  logic                   clk,
	input  sli_pkg::sli_cell_cmd_t cmd,
	input  sli_pkg::sli_cnt_t      cnt,
	output sli_pkg::sli_key_t      head
);
	import sli_pkg::*;

	logic     occ [SLI_CAPACITY];
	logic     ge  [SLI_CAPACITY];
	sli_key_t val [SLI_CAPACITY];

	assign head = val[0];

	for (genvar i = 0; i < SLI_CAPACITY; i++) begin : g_cell
		logic     p_occ;
		logic     p_ge;
		sli_key_t p_val;
		logic     n_occ;
		sli_key_t n_val;

		assign occ[i] = cnt > SLI_CNT_W'(i);

		if (i == 0) begin : g_head
			assign p_occ = 1'b1;
			assign p_ge  = 1'b0;
			assign p_val = val[0];
		end else begin : g_mid
			assign p_occ = occ[i-1];
			assign p_ge  = ge[i-1];
			assign p_val = val[i-1];
		end

		if (i == SLI_CAPACITY - 1) begin : g_tail
			assign n_occ = 1'b0;
			assign n_val = val[i];
		end else begin : g_body
			assign n_occ = occ[i+1];
			assign n_val = val[i+1];
		end

		sli_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occ      (occ[i]),
			.prev_occ (p_occ),
			.prev_ge  (p_ge),
			.prev_val (p_val),
			.next_occ (n_occ),
			.next_val (n_val),
			.head_val (val[0]),
			.ge       (ge[i]),
			.val      (val[i])
		);
	end

endmodule

// ----- src/sorted_list_insert_top.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_top
// Bounded ascending store of signed keys with insert and in-order dump.
// ----------------------------------------------------------------------------
// An insert broadcasts the key along a row of compare-and-shift cells: every
// key not below it moves up one place in the same edge and one status beat
// follows; a full store drops the key and reports full. A dump of n keys
// occupies the block from the accepting cycle through its last beat, one beat
// per cycle while the sink keeps up, as the row rotates its occupied cells
// past the head and comes back to its original order; no item is accepted
// meanwhile. An empty dump gives a single beat without a value. A new item is
// accepted in the same edge at which the sink takes the waiting beat; while a
// beat waits unread, the input is held off.
module sorted_list_insert_top (
	input  logic         clk,
	input  logic         arst_n,
	sli_item_if.sink     items,
	sli_result_if.source results
);
	import sli_pkg::*;

	sli_state_t    state_q, state_d;
	sli_cnt_t      cnt_q, cnt_d;
	sli_cnt_t      rem_q, rem_d;
	sli_cell_cmd_t cmd;
	sli_key_t      head;

	logic     ov_q, ov_d;
	sli_key_t oval_q, oval_d;
	logic     opres_q, opres_d;
	logic     olast_q, olast_d;
	logic     ostat_q, ostat_d;

	logic out_free;
	logic acc;
	logic full;

	assign out_free     = !ov_q || results.ready;
	assign items.ready  = (state_q == ST_IDLE) && out_free;
	assign acc          = items.valid && items.ready;
	assign full         = cnt_q == SLI_CNT_W'(SLI_CAPACITY);

	assign results.valid         = ov_q;
	assign results.value         = oval_q;
	assign results.value_present = opres_q;
	assign results.last          = olast_q;
	assign results.status        = ostat_q;

	sli_chain u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.cnt  (cnt_q),
		.head (head)
	);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		cmd.op   = CELL_HOLD;
		cmd.key  = items.key;
		ov_d     = ov_q && !results.ready;
		oval_d   = oval_q;
		opres_d  = opres_q;
		olast_d  = olast_q;
		ostat_d  = ostat_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					ov_d    = 1'b1;
					oval_d  = '0;
					opres_d = 1'b0;
					olast_d = 1'b1;
					ostat_d = STATUS_OK;
					if (items.operation == OP_INSERT) begin
						if (full) begin
							ostat_d = STATUS_FULL;
						end else begin
							cmd.op = CELL_INSERT;
							cnt_d  = cnt_q + 1'b1;
						end
					end else if (cnt_q != '0) begin
						ov_d    = ov_q && !results.ready;
						rem_d   = cnt_q;
						state_d = ST_DUMP;
					end
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					cmd.op  = CELL_ROTATE;
					ov_d    = 1'b1;
					oval_d  = head;
					opres_d = 1'b1;
					olast_d = rem_q == SLI_CNT_W'(1);
					ostat_d = STATUS_OK;
					rem_d   = rem_q - 1'b1;
					if (rem_q == SLI_CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rem_q   <= rem_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		oval_q  <= oval_d;
		opres_q <= opres_d;
		olast_q <= olast_d;
		ostat_q <= ostat_d;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLI_CNT_W'(SLI_CAPACITY))
		else $error("entry count above capacity");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && items.operation == OP_INSERT && !full |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not grow the store");

	a_dump_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP |-> rem_q != '0 && rem_q <= cnt_q)
		else $error("dump counter out of range");

	a_full_beat: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status == STATUS_FULL |-> !results.value_present
		&& results.last)
		else $error("full status on a value beat");

endmodule

// ----- verif/sorted_list_insert_top_test.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_top_test
// Self-checking bench for the sorted list insertion block. A shadow list
// predicts the answer beats of every accepted insert or dump, and a monitor
// compares each returned beat with the oldest prediction, field by field.
// Directed items cover the empty dump, extreme and equal keys and key bits on
// a dump. Random items then fill the store past capacity under random idling
// on both sides, one long receiver hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module sorted_list_insert_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sli_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		sli_op_t  op;
		sli_key_t key;
	} list_req_t;

	typedef struct packed {
		sli_key_t    value;
		logic        present;
		logic        last;
		sli_status_t status;
	} list_answer_t;

	logic clk;
	logic arst_n;

	sli_item_if   item_ch ();
	sli_result_if result_ch ();

	sorted_list_insert_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch)
	);

	list_req_t    req_backlog[$];
	list_answer_t answers_due[$];

	sli_key_t shadow_keys[SLI_CAPACITY];
	int       shadow_count = 0;

	int  mismatches   = 0;
	int  beats_seen   = 0;
	int  cycles       = 0;
	int  send_gap     = 0;
	int  stall_left   = 0;
	bit  idling_on    = 1'b1;
	bit  hold_request = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("mismatch at beat %0d: %s got %h want %h", beats_seen, what, got, want);
	endtask

	function automatic void shadow_apply(input sli_op_t op, input sli_key_t key);
		int pos;
		if (op == OP_INSERT) begin
			if (shadow_count >= SLI_CAPACITY) begin
				answers_due.push_back('{value: '0, present: 1'b0, last: 1'b1,
					status: STATUS_FULL});
				return;
			end
			pos = 0;
			while (pos < shadow_count && shadow_keys[pos] < key)
				pos++;
			for (int i = shadow_count; i > pos; i--)
				shadow_keys[i] = shadow_keys[i-1];
			shadow_keys[pos] = key;
			shadow_count++;
			answers_due.push_back('{value: '0, present: 1'b0, last: 1'b1, status: STATUS_OK});
		end else if (shadow_count == 0) begin
			answers_due.push_back('{value: '0, present: 1'b0, last: 1'b1, status: STATUS_OK});
		end else begin
			for (int i = 0; i < shadow_count; i++)
				answers_due.push_back('{value: shadow_keys[i], present: 1'b1,
					last: (i == shadow_count - 1), status: STATUS_OK});
		end
	endfunction

	// item driver
	always @(posedge clk) begin
		list_req_t nxt;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				shadow_apply(sli_op_t'(item_ch.operation), item_ch.key);
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_ch.valid <= 1'b0;
				end else if (idling_on && req_backlog.size() > 0 && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 12);
					item_ch.valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					nxt = req_backlog.pop_front();
					item_ch.valid     <= 1'b1;
					item_ch.operation <= nxt.op;
					item_ch.key       <= nxt.key;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		list_answer_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				beats_seen++;
				if (answers_due.size() == 0) begin
					note_mismatch("unexpected beat, value", result_ch.value, '0);
				end else begin
					want = answers_due.pop_front();
					if (result_ch.value !== want.value)
						note_mismatch("value", result_ch.value, want.value);
					if (result_ch.value_present !== want.present)
						note_mismatch("value_present", 32'(result_ch.value_present),
							32'(want.present));
					if (result_ch.last !== want.last)
						note_mismatch("last", 32'(result_ch.last), 32'(want.last));
					if (result_ch.status !== want.status)
						note_mismatch("status", 32'(result_ch.status), 32'(want.status));
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 12);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	int gen_fill = 0;

	task automatic queue_req(input sli_op_t op, input sli_key_t key);
		req_backlog.push_back('{op: op, key: key});
		if (op == OP_INSERT && gen_fill < SLI_CAPACITY)
			gen_fill++;
	endtask

	function automatic sli_key_t pick_key();
		case ($urandom_range(0, 7))
			0: pick_key = 32'sh8000_0000;
			1: pick_key = 32'sh7fff_ffff;
			2: pick_key = -1;
			3, 4: pick_key = $signed($urandom_range(0, 8)) - 4;
			default: pick_key = $urandom;
		endcase
	endfunction

	task automatic queue_random(input int n);
		sli_op_t op;
		for (int i = 0; i < n; i++) begin
			if (gen_fill < SLI_CAPACITY)
				op = ($urandom_range(0, 99) < 70) ? OP_DUMP : OP_INSERT;
			else
				op = ($urandom_range(0, 99) < 45) ? OP_DUMP : OP_INSERT;
			queue_req(op, op == OP_DUMP ? sli_key_t'($urandom) : pick_key());
		end
	endtask

	task automatic wait_backlog_below(input int n);
		do @(negedge clk); while (req_backlog.size() > n);
	endtask

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		item_ch.valid     = 1'b0;
		item_ch.operation = OP_INSERT;
		item_ch.key       = '0;
		result_ch.ready   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty store, extremes, equal keys, key bits on a dump
		queue_req(OP_DUMP,   32'shffff_ffff);
		queue_req(OP_INSERT, 32'sh0000_0000);
		queue_req(OP_INSERT, 32'sh7fff_ffff);
		queue_req(OP_INSERT, 32'sh8000_0000);
		queue_req(OP_DUMP,   32'sh0000_0000);
		queue_req(OP_INSERT, -1);
		queue_req(OP_INSERT, 1);
		queue_req(OP_INSERT, 32'sh0000_0000);
		queue_req(OP_INSERT, 32'sh8000_0000);
		queue_req(OP_INSERT, 32'sh7fff_ffff);
		queue_req(OP_DUMP,   32'sh8000_0000);
		queue_req(OP_INSERT, 32'sh5555_aaaa);
		queue_req(OP_DUMP,   32'sh7fff_ffff);

		// sender waits for every answer
		do @(negedge clk);
		while (req_backlog.size() > 0 || item_ch.valid || answers_due.size() > 0);

		queue_random(70);
		wait_backlog_below(50);
		hold_request = 1'b1;
		wait_backlog_below(0);
		queue_random(50);
		wait_backlog_below(0);

		// full rate to the end
		idling_on = 1'b0;
		queue_random(30);
		do @(negedge clk);
		while (req_backlog.size() > 0 || item_ch.valid || answers_due.size() > 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
